>>> rtl/core/cau_pkg.sv
// Package for the complex arithmetic unit.
// Holds the operation and status codes, the word types of both channels and the clamp helpers.
// No dependencies.
`default_nettype none

package cau_pkg;

    localparam int DATA_W = 32;
    localparam int LIN_W  = 33;
    localparam int PROD_W = 64;
    localparam int SUM_W  = 66;
    localparam int MAG_W  = 64;
    localparam int ITER   = 32;
    localparam int REM_W  = 34;
    localparam int CUR_W  = 36;

    localparam logic [3:0] ACT_ADD   = 4'd0;
    localparam logic [3:0] ACT_SUB   = 4'd1;
    localparam logic [3:0] ACT_MUL   = 4'd2;
    localparam logic [3:0] ACT_DIV   = 4'd3;
    localparam logic [3:0] ACT_SCALE = 4'd4;
    localparam logic [3:0] ACT_SDIV  = 4'd5;
    localparam logic [3:0] ACT_MAG   = 4'd6;
    localparam logic [3:0] ACT_SQMAG = 4'd7;
    localparam logic [3:0] ACT_CONJ  = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    localparam logic signed [DATA_W-1:0] MAX_V = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_V = 32'sh8000_0000;

    typedef struct packed {
        logic [3:0]               action;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
        logic signed [DATA_W-1:0] scalar;
    } cau_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_re;
        logic signed [DATA_W-1:0] out_im;
        logic [1:0]               status;
    } cau_out_t;

    typedef struct packed {
        logic [3:0]               action;
        logic                     dz;
        logic                     neg_re;
        logic                     neg_im;
        logic                     dsat;
        logic signed [DATA_W-1:0] dre;
        logic signed [DATA_W-1:0] dim;
    } cau_ctl_t;

    // {sat, value} of a wide signed value clamped to 32 bits
    function automatic logic [DATA_W:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [DATA_W:0] res;
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]))
            res = {1'b0, v[DATA_W-1:0]};
        else if (v[SUM_W-1])
            res = {1'b1, MIN_V};
        else
            res = {1'b1, MAX_V};
        return res;
    endfunction

    // {sat, value} of a quotient magnitude with sign
    function automatic logic [DATA_W:0] quo_sat(input logic neg, input logic ovf,
                                                 input logic [DATA_W-1:0] q);
        logic [DATA_W:0] res;
        if (neg) begin
            if (ovf || q > 32'h8000_0000)
                res = {1'b1, MIN_V};
            else
                res = {1'b0, 32'h0 - q};
        end
        else begin
            if (ovf || q[DATA_W-1])
                res = {1'b1, MAX_V};
            else
                res = {1'b0, q};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/complex_arithmetic_unit_core.sv
// Complex arithmetic unit top level: multipliers, sum stage, pipelined dividers and square root.
// Depends on cau_pkg.
`default_nettype none

// Usage:
//   in_data (cau_pkg::cau_in_t) is taken on in_valid && in_ready; one result word
//   (cau_pkg::cau_out_t) leaves on out_valid && out_ready for every input word, in order.
//   Operations: add, sub, mul, div, scale, scalar divide, magnitude, squared magnitude,
//   conjugate. Status: ok, divide by zero, saturated.
// Pipeline: stages are the multipliers, the sums, the sign/magnitude split, the divider
//   setup and 32 restoring steps shared in depth by the two quotient lanes and the square
//   root lane, then the output register.
// Throughput: one word per cycle while not stalled; the 32-step quotient/root pipe sets the depth.
// Stall: the whole pipe holds while out_valid is high and out_ready is low;
//   in_ready = !out_valid || out_ready, so nothing is lost or repeated.
// Reset: clears all valid bits; the block is stateless otherwise.
module complex_arithmetic_unit_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cau_pkg::cau_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cau_pkg::cau_out_t     out_data
);

    localparam int N = cau_pkg::ITER;

    logic adv;
    logic out_valid_reg;
    cau_pkg::cau_out_t out_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 1: products and the add/sub/conjugate results
    logic s1_valid_reg;
    logic [3:0] s1_act_reg;
    logic signed [cau_pkg::PROD_W-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [cau_pkg::PROD_W-1:0] m0_next, m1_next, m2_next, m3_next, m4_next, m5_next;
    logic signed [cau_pkg::LIN_W-1:0] lre_reg, lim_reg, lre_next, lim_next;
    logic signed [cau_pkg::DATA_W-1:0] ar_reg, ai_reg, sc_reg;
    logic signed [cau_pkg::DATA_W-1:0] op0, op1;

    always_comb
    begin
        op0 = in_data.b_re;
        op1 = in_data.b_im;
        if (in_data.action == cau_pkg::ACT_SCALE)
        begin
            op0 = in_data.scalar;
            op1 = in_data.scalar;
        end
        else if (in_data.action == cau_pkg::ACT_MAG || in_data.action == cau_pkg::ACT_SQMAG)
        begin
            op0 = in_data.a_re;
            op1 = in_data.a_im;
        end
        m0_next = in_data.a_re * op0;
        m1_next = in_data.a_im * op1;
        m2_next = in_data.a_re * in_data.b_im;
        m3_next = in_data.a_im * in_data.b_re;
        m4_next = in_data.b_re * in_data.b_re;
        m5_next = in_data.b_im * in_data.b_im;
        case (in_data.action)
            cau_pkg::ACT_ADD:
            begin
                lre_next = cau_pkg::LIN_W'(in_data.a_re) + cau_pkg::LIN_W'(in_data.b_re);
                lim_next = cau_pkg::LIN_W'(in_data.a_im) + cau_pkg::LIN_W'(in_data.b_im);
            end
            cau_pkg::ACT_SUB:
            begin
                lre_next = cau_pkg::LIN_W'(in_data.a_re) - cau_pkg::LIN_W'(in_data.b_re);
                lim_next = cau_pkg::LIN_W'(in_data.a_im) - cau_pkg::LIN_W'(in_data.b_im);
            end
            cau_pkg::ACT_CONJ:
            begin
                lre_next = cau_pkg::LIN_W'(in_data.a_re);
                lim_next = -cau_pkg::LIN_W'(in_data.a_im);
            end
            default:
            begin
                lre_next = '0;
                lim_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_act_reg <= in_data.action;
            m0_reg     <= m0_next;
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            m3_reg     <= m3_next;
            m4_reg     <= m4_next;
            m5_reg     <= m5_next;
            lre_reg    <= lre_next;
            lim_reg    <= lim_next;
            ar_reg     <= in_data.a_re;
            ai_reg     <= in_data.a_im;
            sc_reg     <= in_data.scalar;
        end
    end

    // stage 2: sums and divisor
    logic s2_valid_reg;
    logic [3:0] s2_act_reg;
    logic signed [cau_pkg::SUM_W-1:0] sre_reg, sim_reg, sre_next, sim_next;
    logic [cau_pkg::MAG_W-1:0] den2_reg, den2_next;
    logic dneg_reg, dneg_next;
    logic signed [cau_pkg::SUM_W-1:0] e0, e1, e2, e3;
    logic signed [cau_pkg::LIN_W-1:0] sc_abs;

    always_comb
    begin
        e0 = cau_pkg::SUM_W'(m0_reg);
        e1 = cau_pkg::SUM_W'(m1_reg);
        e2 = cau_pkg::SUM_W'(m2_reg);
        e3 = cau_pkg::SUM_W'(m3_reg);
        sc_abs = sc_reg[cau_pkg::DATA_W-1] ? -cau_pkg::LIN_W'(sc_reg)
                                            : cau_pkg::LIN_W'(sc_reg);
        sre_next  = '0;
        sim_next  = '0;
        den2_next = '0;
        dneg_next = 1'b0;
        case (s1_act_reg)
            cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_CONJ:
            begin
                sre_next = cau_pkg::SUM_W'(lre_reg);
                sim_next = cau_pkg::SUM_W'(lim_reg);
            end
            cau_pkg::ACT_MUL:
            begin
                sre_next = e0 - e1;
                sim_next = e2 + e3;
            end
            cau_pkg::ACT_DIV:
            begin
                sre_next  = e0 + e1;
                sim_next  = e3 - e2;
                den2_next = $unsigned(m4_reg) + $unsigned(m5_reg);
            end
            cau_pkg::ACT_SCALE:
            begin
                sre_next = e0;
                sim_next = e1;
            end
            cau_pkg::ACT_SDIV:
            begin
                sre_next  = cau_pkg::SUM_W'(ar_reg);
                sim_next  = cau_pkg::SUM_W'(ai_reg);
                den2_next = cau_pkg::MAG_W'($unsigned(sc_abs));
                dneg_next = sc_reg[cau_pkg::DATA_W-1];
            end
            cau_pkg::ACT_MAG, cau_pkg::ACT_SQMAG:
            begin
                sre_next = e0 + e1;
            end
            default:
            begin
                sre_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_act_reg <= s1_act_reg;
            sre_reg    <= sre_next;
            sim_reg    <= sim_next;
            den2_reg   <= den2_next;
            dneg_reg   <= dneg_next;
        end
    end

    // stage 3: sign/magnitude and direct results
    logic s3_valid_reg;
    cau_pkg::cau_ctl_t ctl3_reg, ctl3_next;
    logic [cau_pkg::MAG_W-1:0] mre_reg, mim_reg, mre_next, mim_next, den3_reg;
    logic signed [cau_pkg::SUM_W-1:0] nre, nim, fre, fim;
    logic [cau_pkg::DATA_W:0] cre, cim;

    always_comb
    begin
        nre = -sre_reg;
        nim = -sim_reg;
        mre_next = sre_reg[cau_pkg::SUM_W-1] ? nre[cau_pkg::MAG_W-1:0]
                                             : sre_reg[cau_pkg::MAG_W-1:0];
        mim_next = sim_reg[cau_pkg::SUM_W-1] ? nim[cau_pkg::MAG_W-1:0]
                                             : sim_reg[cau_pkg::MAG_W-1:0];
        fre = sre_reg >>> FRAC_BITS;
        fim = sim_reg >>> FRAC_BITS;
        cre = '0;
        cim = '0;
        case (s2_act_reg)
            cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_CONJ:
            begin
                cre = cau_pkg::sat32(sre_reg);
                cim = cau_pkg::sat32(sim_reg);
            end
            cau_pkg::ACT_MUL, cau_pkg::ACT_SCALE, cau_pkg::ACT_SQMAG:
            begin
                cre = cau_pkg::sat32(fre);
                cim = cau_pkg::sat32(fim);
            end
            default:
            begin
                cre = '0;
            end
        endcase
        ctl3_next.action = s2_act_reg;
        ctl3_next.dz     = (s2_act_reg == cau_pkg::ACT_DIV || s2_act_reg == cau_pkg::ACT_SDIV)
                           && den2_reg == '0;
        ctl3_next.neg_re = sre_reg[cau_pkg::SUM_W-1] ^ dneg_reg;
        ctl3_next.neg_im = sim_reg[cau_pkg::SUM_W-1] ^ dneg_reg;
        ctl3_next.dsat   = cre[cau_pkg::DATA_W] | cim[cau_pkg::DATA_W];
        ctl3_next.dre    = cre[cau_pkg::DATA_W-1:0];
        ctl3_next.dim    = cim[cau_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl3_reg <= ctl3_next;
            mre_reg  <= mre_next;
            mim_reg  <= mim_next;
            den3_reg <= den2_reg;
        end
    end

    // quotient / root pipe, index 0 is the setup stage
    logic                        v_reg   [0:N];
    cau_pkg::cau_ctl_t           ctl_reg [0:N];
    logic [cau_pkg::MAG_W-1:0]   den_reg [0:N];
    logic [cau_pkg::MAG_W-1:0]   rre_reg [0:N];
    logic [cau_pkg::MAG_W-1:0]   rim_reg [0:N];
    logic [cau_pkg::DATA_W-1:0]  nre_reg [0:N];
    logic [cau_pkg::DATA_W-1:0]  nim_reg [0:N];
    logic [cau_pkg::DATA_W-1:0]  qre_reg [0:N];
    logic [cau_pkg::DATA_W-1:0]  qim_reg [0:N];
    logic                        ore_reg [0:N];
    logic                        oim_reg [0:N];
    logic [cau_pkg::REM_W-1:0]   rem_reg [0:N];
    logic [cau_pkg::DATA_W-1:0]  root_reg[0:N];
    logic [cau_pkg::MAG_W-1:0]   sm_reg  [0:N];

    logic [cau_pkg::MAG_W-1:0] r0re_next, r0im_next, shre, shim;

    always_comb
    begin
        r0re_next = mre_reg >> (cau_pkg::DATA_W - FRAC_BITS);
        r0im_next = mim_reg >> (cau_pkg::DATA_W - FRAC_BITS);
        shre      = mre_reg << FRAC_BITS;
        shim      = mim_reg << FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0]  <= ctl3_reg;
            den_reg[0]  <= den3_reg;
            rre_reg[0]  <= r0re_next;
            rim_reg[0]  <= r0im_next;
            ore_reg[0]  <= r0re_next >= den3_reg;
            oim_reg[0]  <= r0im_next >= den3_reg;
            nre_reg[0]  <= shre[cau_pkg::DATA_W-1:0];
            nim_reg[0]  <= shim[cau_pkg::DATA_W-1:0];
            qre_reg[0]  <= '0;
            qim_reg[0]  <= '0;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            sm_reg[0]   <= mre_reg;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_step
        logic [cau_pkg::MAG_W:0]   r2re, r2im, dx;
        logic [cau_pkg::MAG_W:0]   dre_diff, dim_diff;
        logic                      gre, gim, gsq;
        logic [cau_pkg::CUR_W-1:0] cur, trial, sdiff;
        logic [cau_pkg::MAG_W-1:0] rre_next, rim_next;
        logic [cau_pkg::REM_W-1:0] rem_next;
        logic [cau_pkg::DATA_W-1:0] root_next;

        always_comb
        begin
            dx       = {1'b0, den_reg[k-1]};
            r2re     = {rre_reg[k-1], nre_reg[k-1][cau_pkg::DATA_W-1]};
            r2im     = {rim_reg[k-1], nim_reg[k-1][cau_pkg::DATA_W-1]};
            gre      = r2re >= dx;
            gim      = r2im >= dx;
            dre_diff = r2re - dx;
            dim_diff = r2im - dx;
            rre_next = gre ? dre_diff[cau_pkg::MAG_W-1:0] : r2re[cau_pkg::MAG_W-1:0];
            rim_next = gim ? dim_diff[cau_pkg::MAG_W-1:0] : r2im[cau_pkg::MAG_W-1:0];
            cur      = {rem_reg[k-1], sm_reg[k-1][cau_pkg::MAG_W-1:cau_pkg::MAG_W-2]};
            trial    = {2'b00, root_reg[k-1], 2'b01};
            gsq      = cur >= trial;
            sdiff    = cur - trial;
            rem_next = gsq ? sdiff[cau_pkg::REM_W-1:0] : cur[cau_pkg::REM_W-1:0];
            root_next = {root_reg[k-1][cau_pkg::DATA_W-2:0], gsq};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctl_reg[k]  <= ctl_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                rre_reg[k]  <= rre_next;
                rim_reg[k]  <= rim_next;
                nre_reg[k]  <= {nre_reg[k-1][cau_pkg::DATA_W-2:0], 1'b0};
                nim_reg[k]  <= {nim_reg[k-1][cau_pkg::DATA_W-2:0], 1'b0};
                qre_reg[k]  <= {qre_reg[k-1][cau_pkg::DATA_W-2:0], gre};
                qim_reg[k]  <= {qim_reg[k-1][cau_pkg::DATA_W-2:0], gim};
                ore_reg[k]  <= ore_reg[k-1];
                oim_reg[k]  <= oim_reg[k-1];
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                sm_reg[k]   <= {sm_reg[k-1][cau_pkg::MAG_W-3:0], 2'b00};
            end
        end
    end

    // result select
    cau_pkg::cau_out_t out_next;
    cau_pkg::cau_ctl_t cl;
    logic [cau_pkg::DATA_W:0] qr, qi;

    always_comb
    begin
        cl = ctl_reg[N];
        qr = cau_pkg::quo_sat(cl.neg_re, ore_reg[N], qre_reg[N]);
        qi = cau_pkg::quo_sat(cl.neg_im, oim_reg[N], qim_reg[N]);
        out_next.out_re = '0;
        out_next.out_im = '0;
        out_next.status = cau_pkg::ST_OK;
        case (cl.action)
            cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_CONJ,
            cau_pkg::ACT_MUL, cau_pkg::ACT_SCALE, cau_pkg::ACT_SQMAG:
            begin
                out_next.out_re = cl.dre;
                out_next.out_im = cl.dim;
                out_next.status = cl.dsat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            cau_pkg::ACT_DIV, cau_pkg::ACT_SDIV:
            begin
                if (cl.dz)
                begin
                    out_next.status = cau_pkg::ST_DIV_ZERO;
                end
                else
                begin
                    out_next.out_re = qr[cau_pkg::DATA_W-1:0];
                    out_next.out_im = qi[cau_pkg::DATA_W-1:0];
                    out_next.status = (qr[cau_pkg::DATA_W] | qi[cau_pkg::DATA_W])
                                      ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::ACT_MAG:
            begin
                if (root_reg[N][cau_pkg::DATA_W-1])
                begin
                    out_next.out_re = cau_pkg::MAX_V;
                    out_next.status = cau_pkg::ST_SAT;
                end
                else
                begin
                    out_next.out_re = root_reg[N];
                end
            end
            default:
            begin
                out_next.status = cau_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == cau_pkg::ST_DIV_ZERO
        |-> out_reg.out_re == '0 && out_reg.out_im == '0)
        else $error("divide-by-zero word with nonzero parts");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.status != 2'd3)
        else $error("undefined status code");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg[N]) && $stable(s1_valid_reg))
        else $error("pipe moved during stall");

endmodule

`default_nettype wire
